// File: src/segment_fit_allocator_unit_macros.svh
// Assertion macros used by the checker file (sfa_checker).
`ifndef SEGMENT_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define SEGMENT_FIT_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/sfa_pkg.sv
package sfa_pkg;

  localparam int MaxSegmentsDef = 64;
  localparam int AddrBitsDef    = 16;
  localparam int FieldW         = 16;
  localparam int IdW            = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic CFG_SPAN = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [15:0] release_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] region_start;
    logic [15:0] region_length;
    logic [15:0] region_id;
    logic [15:0] free_units;
  } rsp_t;

  // One segment as it moves along the chain.
  typedef struct packed {
    logic        used;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] id;
  } seg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_SHIFT, S_DONE
  } state_t;

  // Operation the cells perform.
  typedef enum logic [2:0] {
    OP_HOLD, OP_INIT, OP_MARK, OP_INSERT, OP_DROP, OP_ROTATE
  } op_t;

  // Control broadcast to all cells.
  typedef struct packed {
    op_t         op;
    logic [10:0] pos;
    seg_t        wdata;
    logic [15:0] span;
  } cell_ctl_t;

endpackage

// File: src/sfa_cell.sv
module sfa_cell #(
  parameter int IDX_BITS = 6,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  sfa_pkg::cell_ctl_t ctl,
  input  sfa_pkg::seg_t     left,
  input  sfa_pkg::seg_t     right,
  output sfa_pkg::seg_t     seg
);
  import sfa_pkg::*;

  localparam logic [IDX_BITS-1:0] MyIdx = IDX_BITS'(INDEX);

  logic [IDX_BITS-1:0] pos;
  seg_t seg_next;

  assign pos = ctl.pos[IDX_BITS-1:0];

  // Pick this cell's next content from itself, a neighbor or the control word.
  always_comb begin
    seg_next = seg;
    unique case (ctl.op)
      OP_INIT: begin
        if (MyIdx == '0) begin
          seg_next = '{used: 1'b0, start: 16'd0, length: ctl.span, id: 16'd0};
        end
      end
      OP_MARK: begin
        if (MyIdx == pos) seg_next = ctl.wdata;
      end
      OP_INSERT: begin
        if (MyIdx == pos) seg_next = ctl.wdata;
        else if (MyIdx > pos) seg_next = left;
      end
      OP_DROP: begin
        if (MyIdx >= pos) seg_next = right;
      end
      OP_ROTATE: seg_next = right;
      default: seg_next = seg;
    endcase
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
  end
endmodule

// File: src/sfa_chain.sv
module sfa_chain #(
  parameter int MAX_SEGMENTS = sfa_pkg::MaxSegmentsDef,
  parameter int IDX_BITS = 6
) (
  input  logic               clk,
  input  sfa_pkg::cell_ctl_t ctl,
  output sfa_pkg::seg_t      head,
  output sfa_pkg::seg_t      second
);
  import sfa_pkg::*;

  seg_t segs [MAX_SEGMENTS];

  // Row of cells; on rotate each takes its right neighbor and the first wraps to the last.
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    sfa_cell #(.IDX_BITS(IDX_BITS), .INDEX(g)) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left ((g == 0) ? segs[MAX_SEGMENTS-1] : segs[(g == 0) ? 0 : g-1]),
      .right(segs[(g + 1) % MAX_SEGMENTS]),
      .seg  (segs[g])
    );
  end

  assign head   = segs[0];
  assign second = segs[1];
endmodule

// File: src/segment_fit_allocator_unit.sv
// Segment fit allocator.
// Requests arrive on in_valid/in_ready with a req_t beat: allocate a size or
// release an id. Each request gives exactly one rsp_t beat on out_valid/
// out_ready. Configuration writes (cfg_index 0 span, 1 fit mode) land on
// cfg_valid/cfg_ready; a span write reinitializes the table to one hole.
// Segments live in a row of MAX_SEGMENTS cells that rotate by one entry per
// cycle while a request is scanned. A request takes one full rotation to scan,
// after which the order is back in place. Then a decide state (APPLY), the edit
// steps in SHIFT (exact fit: one mark; failure: none; split: insert, then mark;
// release: drop next, drop self, mark) and a DONE state that raises out_valid.
// The next request can be taken in the cycle after the result beat is accepted.
// Reset (rst, synchronous) leaves one hole of SpanLim units (65535 when
// ADDR_BITS is 16 or more), first fit, id 0.
// A stalled receiver holds the result; no new request is accepted until then.
module segment_fit_allocator_unit #(
  parameter int MAX_SEGMENTS = sfa_pkg::MaxSegmentsDef,
  parameter int ADDR_BITS    = sfa_pkg::AddrBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sfa_pkg::rsp_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import sfa_pkg::*;

  localparam int IdxBits = $clog2(MAX_SEGMENTS);
  localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CntBits-1:0] MaxCnt = CntBits'(MAX_SEGMENTS);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(MAX_SEGMENTS - 1);
  localparam logic [16:0] SpanLim =
    (ADDR_BITS >= 16) ? 17'h0ffff : 17'((1 << ADDR_BITS) - 1);

  state_t state, state_next;
  cell_ctl_t ctl;
  seg_t head, second;

  logic [15:0] span;
  logic [1:0]  mode;
  logic [CntBits-1:0] count;
  logic [15:0] next_id;
  logic [15:0] free_space;
  req_t req;
  logic [IdxBits-1:0] scan;
  logic found;
  logic [IdxBits-1:0] pick;
  seg_t pick_seg;
  logic [IdxBits-1:0] rot;
  logic init_pend;
  logic [15:0] rel_start, rel_len;
  logic prev_hole;
  logic [15:0] prev_start, prev_len;
  seg_t prev_seg;
  rsp_t rsp;
  logic [2:0] rel_kind;
  logic apply_done;

  logic valid_entry, better, rel_hit;
  logic [16:0] span_sat;

  assign span_sat = (17'(cfg_data) > SpanLim) ? SpanLim : 17'(cfg_data);
  assign in_ready  = (state == S_IDLE) && !out_valid && !init_pend;
  assign cfg_ready = (state == S_IDLE);

  // Scan view: cell 0 holds table entry scan after scan rotations.
  assign valid_entry = (CntBits'(scan) < count);
  always_comb begin
    better = 1'b0;
    if (!found) better = 1'b1;
    else if (mode == FIT_WORST) better = head.length > pick_seg.length;
    else if (mode == FIT_BEST) better = head.length < pick_seg.length;
  end
  assign rel_hit = valid_entry && head.used && head.id == req.release_id;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      span <= SpanLim[15:0];
      mode <= FIT_FIRST;
      init_pend <= 1'b1;
      count <= CntBits'(1);
      next_id <= '0;
      free_space <= SpanLim[15:0];
      out_valid <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready && cfg_index == CFG_SPAN) init_pend <= 1'b1;
      else if (state == S_IDLE && init_pend) init_pend <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SPAN) begin
          span <= span_sat[15:0];
          count <= CntBits'(1);
          next_id <= '0;
          free_space <= span_sat[15:0];
        end else begin
          mode <= cfg_data[1:0];
        end
      end
      if (state == S_IDLE && in_valid && in_ready) begin
        req <= in_data;
        scan <= '0;
        found <= 1'b0;
        prev_hole <= 1'b0;
        rel_kind <= '0;
      end
      if (state == S_SCAN) begin
        scan <= scan + 1'b1;
        if (req.action == ACT_ALLOC) begin
          if (valid_entry && !head.used && head.length >= req.request_size &&
              req.request_size != 16'd0 && better) begin
            found <= 1'b1;
            pick <= scan;
            pick_seg <= head;
          end
        end else if (!found) begin
          if (rel_hit) begin
            found <= 1'b1;
            pick <= scan;
            pick_seg <= head;
            // Note neighbors: previous hole and next entry.
            rel_kind[0] <= prev_hole;
            rel_start <= prev_hole ? prev_start : head.start;
            rel_len <= prev_hole ? 16'(prev_len + head.length) : head.length;
            rel_kind[1] <= (CntBits'(scan) + 1'b1 < count) && !second.used;
            prev_seg <= second;
          end
          prev_hole <= valid_entry && !head.used;
          prev_start <= head.start;
          prev_len <= head.length;
        end
      end
      if (state == S_APPLY) begin
        if (req.action == ACT_ALLOC) begin
          if (!found) begin
            rsp <= '{status: ST_NO_FIT, region_start: 16'd0, region_length: 16'd0,
                     region_id: 16'd0, free_units: free_space};
          end else if (pick_seg.length != req.request_size && count >= MaxCnt) begin
            rsp <= '{status: ST_FULL, region_start: 16'd0, region_length: 16'd0,
                     region_id: 16'd0, free_units: free_space};
          end else begin
            rsp <= '{status: ST_OK, region_start: pick_seg.start,
                     region_length: req.request_size, region_id: next_id,
                     free_units: 16'(free_space - req.request_size)};
            next_id <= next_id + 1'b1;
            free_space <= free_space - req.request_size;
            if (pick_seg.length != req.request_size) count <= count + 1'b1;
          end
        end else begin
          if (!found) begin
            rsp <= '{status: ST_UNKNOWN, region_start: 16'd0, region_length: 16'd0,
                     region_id: 16'd0, free_units: free_space};
          end else begin
            rsp <= '{status: ST_OK, region_start: rel_start,
                     region_length: rel_kind[1] ? 16'(rel_len + prev_seg.length)
                                                : rel_len,
                     region_id: req.release_id,
                     free_units: 16'(free_space + pick_seg.length)};
            free_space <= free_space + pick_seg.length;
            count <= count - CntBits'(rel_kind[0]) - CntBits'(rel_kind[1]);
          end
        end
      end
      if (state == S_DONE) out_valid <= 1'b1;
    end
  end

  // Steps of the table edit after APPLY: rel edits run as a short micro list.
  logic [1:0] step;
  always_ff @(posedge clk) begin
    if (state == S_APPLY) step <= '0;
    else if (state == S_SHIFT) step <= step + 1'b1;
  end

  assign apply_done = 1'b1;

  // Next state and cell control.
  always_comb begin
    state_next = state;
    ctl = '{op: OP_HOLD, pos: '0, wdata: '0, span: span};
    unique case (state)
      S_IDLE: begin
        if (init_pend) ctl.op = OP_INIT;
        else if (in_valid && in_ready) state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.op = OP_ROTATE;
        if (scan == LastIdx) state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        state_next = S_SHIFT;
        ctl.pos = 11'(pick);
        if (rsp.status != ST_OK) state_next = S_DONE;
        else if (req.action == ACT_ALLOC) begin
          if (pick_seg.length == req.request_size) begin
            ctl.op = OP_MARK;
            ctl.wdata = '{used: 1'b1, start: pick_seg.start,
                          length: pick_seg.length, id: rsp.region_id};
            state_next = S_DONE;
          end else if (step == 2'd0) begin
            // Open a slot after the hole for the remainder.
            ctl.op = OP_INSERT;
            ctl.pos = 11'(pick) + 11'd1;
            ctl.wdata = '{used: 1'b0, start: 16'(pick_seg.start + req.request_size),
                          length: 16'(pick_seg.length - req.request_size), id: 16'd0};
          end else begin
            ctl.op = OP_MARK;
            ctl.wdata = '{used: 1'b1, start: pick_seg.start,
                          length: req.request_size, id: rsp.region_id};
            state_next = S_DONE;
          end
        end else begin
          // Release: drop next if it is a hole, drop self if the previous is a hole, mark merged entry.
          unique case (step)
            2'd0: begin
              if (rel_kind[1]) ctl.op = OP_DROP;
              ctl.pos = 11'(pick) + 11'd1;
            end
            2'd1: begin
              if (rel_kind[0]) ctl.op = OP_DROP;
            end
            default: begin
              ctl.op = OP_MARK;
              ctl.pos = rel_kind[0] ? 11'(pick) - 11'd1 : 11'(pick);
              ctl.wdata = '{used: 1'b0, start: rsp.region_start,
                            length: rsp.region_length, id: 16'd0};
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (apply_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_data = rsp;

  sfa_chain #(.MAX_SEGMENTS(MAX_SEGMENTS), .IDX_BITS(IdxBits)) u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .head  (head),
    .second(second)
  );
endmodule

// File: src/sfa_checker.sv
module sfa_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sfa_pkg::rsp_t out_data
);
  import sfa_pkg::*;
`include "segment_fit_allocator_unit_macros.svh"

  `SFA_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `SFA_ASSERT_IMP(a_one, clk, rst, in_valid && in_ready, !out_valid, "accept while result pending")
  `SFA_ASSERT_IMP(a_fail, clk, rst, out_valid && out_data.status == ST_NO_FIT, out_data.region_length == 16'd0, "failed request with length")
endmodule

bind segment_fit_allocator_unit sfa_checker u_sfa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
